FILE: rtl/emfp_pkg.sv
// shared types and constants of the energy meter frame parser
`default_nettype none

package emfp_pkg;

  localparam int FrameLen    = 24;
  localparam int PosW        = $clog2(FrameLen + 1);
  localparam int SumFirst    = 2;
  localparam int SumLast     = 22;
  localparam int SumByte     = 23;
  localparam int HeaderByte  = 1;
  localparam logic [7:0] HeaderValue = 8'h5A;

  // byte offsets of the report fields, each value msb first
  localparam int VoltParamAt = 2;
  localparam int VoltDataAt  = 5;
  localparam int CurrParamAt = 8;
  localparam int CurrDataAt  = 11;
  localparam int PowParamAt  = 14;
  localparam int PowDataAt   = 17;
  localparam int FlagsByte   = 20;
  localparam int PulseHiByte = 21;
  localparam int PulseLoByte = 22;

  // bits of the flags byte
  localparam int FlagOverflow = 7;
  localparam int FlagVolt     = 6;
  localparam int FlagCurr     = 5;
  localparam int FlagPow      = 4;

  typedef enum logic [1:0] {
    StOk     = 2'd0,
    StShort  = 2'd1,
    StSum    = 2'd2,
    StHeader = 2'd3
  } status_t;

  // frame as it stands once the current item is taken in
  typedef struct packed {
    logic                        complete;
    logic [7:0]                  sum;
    logic [FrameLen-1:0][7:0]    bytes;
  } frame_view_t;

  typedef struct packed {
    logic [31:0] pulse_overflows;
    logic [15:0] pulse_count;
    logic [23:0] power_data;
    logic [23:0] power_param;
    logic [23:0] current_data;
    logic [23:0] current_param;
    logic [23:0] voltage_data;
    logic [23:0] voltage_param;
    status_t     status;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/emfp_capture.sv
// byte position, running checksum and frame store
`default_nettype none

module emfp_capture (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                accept,
  input  wire logic [7:0]          rx_byte,
  input  wire logic                frame_start,
  input  wire logic                frame_end,
  output emfp_pkg::frame_view_t    view
);
  import emfp_pkg::*;

  localparam logic [PosW-1:0] PosFull  = PosW'(FrameLen);
  localparam logic [PosW-1:0] PosFirst = PosW'(SumFirst);
  localparam logic [PosW-1:0] PosLast  = PosW'(SumLast);

  logic [PosW-1:0] byte_position;
  logic [PosW-1:0] pos_cur;
  logic [PosW-1:0] pos_next;
  logic [7:0]      sum_acc;
  logic [7:0]      sum_cur;
  logic [7:0]      sum_next;
  logic            in_frame;
  logic [7:0]      store [FrameLen];

  always_comb begin
    pos_cur  = frame_start ? '0 : byte_position;
    sum_cur  = frame_start ? '0 : sum_acc;
    in_frame = pos_cur < PosFull;
    pos_next = in_frame ? pos_cur + 1'b1 : pos_cur;
    sum_next = (in_frame && pos_cur >= PosFirst && pos_cur <= PosLast) ?
               sum_cur + rx_byte : sum_cur;
  end

  always_comb begin
    view.complete = pos_next == PosFull;
    view.sum      = sum_next;
    for (int i = 0; i < FrameLen; i++) begin
      view.bytes[i] = (in_frame && pos_cur == PosW'(i)) ? rx_byte : store[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      sum_acc       <= '0;
    end else if (accept) begin
      if (frame_end) begin
        byte_position <= '0;
        sum_acc       <= '0;
      end else begin
        byte_position <= pos_next;
        sum_acc       <= sum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_frame) begin
      store[pos_cur] <= rx_byte;
    end
  end

  assert property (@(posedge clk) disable iff (rst) byte_position <= PosFull)
    else $error("byte position past frame length");

  assert property (@(posedge clk) disable iff (rst)
    accept && frame_end |=> byte_position == '0 && sum_acc == '0)
    else $error("position or sum not cleared after frame end");

endmodule

`default_nettype wire

FILE: rtl/emfp_decode.sv
// frame check, meter registers and result register
`default_nettype none

module emfp_decode (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  fire,
  input  wire emfp_pkg::frame_view_t view,
  input  wire logic                  out_ready,
  output logic                       out_valid,
  output emfp_pkg::result_t          result
);
  import emfp_pkg::*;

  function automatic logic [23:0] take24(input frame_view_t v, input int at);
    take24 = {v.bytes[at], v.bytes[at+1], v.bytes[at+2]};
  endfunction

  status_t     status, status_next;
  logic [23:0] volt_param, volt_data, curr_param, curr_data, pow_param, pow_data;
  logic [15:0] previous_pulses;
  logic [31:0] overflow_counter;
  logic [7:0]  flags;
  logic [15:0] pulses;
  logic        wrapped;

  always_comb begin
    flags   = view.bytes[FlagsByte];
    pulses  = {view.bytes[PulseHiByte], view.bytes[PulseLoByte]};
    wrapped = flags[FlagOverflow] || (previous_pulses > pulses);
    priority if (!view.complete) begin
      status_next = StShort;
    end else if (view.sum != view.bytes[SumByte]) begin
      status_next = StSum;
    end else if (view.bytes[HeaderByte] != HeaderValue) begin
      status_next = StHeader;
    end else begin
      status_next = StOk;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      volt_param       <= '0;
      volt_data        <= '0;
      curr_param       <= '0;
      curr_data        <= '0;
      pow_param        <= '0;
      pow_data         <= '0;
      previous_pulses  <= '0;
      overflow_counter <= '0;
    end else if (fire && status_next == StOk) begin
      volt_param <= take24(view, VoltParamAt);
      curr_param <= take24(view, CurrParamAt);
      pow_param  <= take24(view, PowParamAt);
      if (flags[FlagVolt]) begin
        volt_data <= take24(view, VoltDataAt);
      end
      if (flags[FlagCurr]) begin
        curr_data <= take24(view, CurrDataAt);
      end
      if (flags[FlagPow]) begin
        pow_data <= take24(view, PowDataAt);
      end
      if (wrapped) begin
        overflow_counter <= overflow_counter + 32'd1;
      end
      previous_pulses <= pulses;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      status <= status_next;
    end
  end

  // the meter registers only move on a report, so they hold while it waits
  always_comb begin
    result.status          = status;
    result.voltage_param   = volt_param;
    result.voltage_data    = volt_data;
    result.current_param   = curr_param;
    result.current_data    = curr_data;
    result.power_param     = pow_param;
    result.power_data      = pow_data;
    result.pulse_count     = previous_pulses;
    result.pulse_overflows = overflow_counter;
  end

  assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$stable(overflow_counter) |-> $past(fire) && status == StOk)
    else $error("overflow counter moved without a good frame");

  assert property (@(posedge clk) disable iff (rst)
    fire && status_next != StOk |=> $stable(volt_param) && $stable(previous_pulses))
    else $error("meter registers changed on a bad frame");

  assert property (@(posedge clk) disable iff (rst) $rose(out_valid) |-> $past(fire))
    else $error("result shown without a frame end");

endmodule

`default_nettype wire

FILE: rtl/energy_meter_frame_parser_unit.sv
// top level of the energy meter frame parser
`default_nettype none

// takes one byte of a 24-byte meter report per item (tuser marks the first byte,
// tlast the last) and gives one result item per frame end: a status code
// (0 ok, 1 too short, 2 checksum mismatch, 3 bad header) with the meter
// registers as they stand after the check. a new byte can be taken in every cycle
// unless input is held off; the check runs in the cycle that takes the last byte
// and the result sits in the output register from the next cycle. input is held
// off only while a result waits and the sink is not ready.
// bytes past the 24th are dropped, and a frame end always starts a new frame.

module energy_meter_frame_parser_unit (
  input  wire logic         clk,
  input  wire logic         rst,
  // byte input
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [7:0]   s_axis_tdata,  // rx_byte
  input  wire logic         s_axis_tuser,  // frame_start
  input  wire logic         s_axis_tlast,  // frame_end
  // result output
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // status [1:0], voltage_param [25:2], voltage_data [49:26],
  // current_param [73:50], current_data [97:74], power_param [121:98],
  // power_data [145:122], pulse_count [161:146], pulse_overflows [193:162],
  // zero fill [199:194]
  output logic [199:0]      m_axis_tdata
);
  import emfp_pkg::*;

  frame_view_t view;
  result_t     result;
  logic        accept;
  logic        fire;

  // the output register is free or being emptied this cycle
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign fire          = accept && s_axis_tlast;

  emfp_capture u_capture (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .rx_byte     (s_axis_tdata),
    .frame_start (s_axis_tuser),
    .frame_end   (s_axis_tlast),
    .view        (view)
  );

  emfp_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .view      (view),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .result    (result)
  );

  // result fields packed from the lowest bit up, padded to whole bytes
  assign m_axis_tdata = {6'd0, result};

endmodule

`default_nettype wire

FILE: tb/energy_meter_frame_parser_unit_test.sv
// self-checking testbench of the energy meter frame parser
`timescale 1ns / 100ps

module energy_meter_frame_parser_unit_test;
  import emfp_pkg::*;

  localparam int HalfPeriod    = 2;
  localparam int ResetCycles   = 6;
  localparam int RandomItems   = 1050;
  localparam int StallLimit    = 4000;
  localparam int TailCycles    = 16;
  localparam int ResultW       = $bits(result_t);
  localparam int MaxFrameBytes = 32;

  // shapes of frame the stimulus can build
  typedef enum logic [2:0] {
    FrGood, FrShort, FrLong, FrNoStart, FrBadSum, FrBadHeader, FrBadBoth, FrAbandon
  } frame_kind_t;

  // content of the payload bytes
  typedef enum logic [1:0] {
    FillRand, FillZero, FillOnes
  } fill_t;

  // how much of a directed report is typed in by hand
  typedef enum logic [1:0] {
    PinNone,     // all from the predictor
    PinStatus,   // status typed in, registers from the predictor
    PinCleared   // status typed in, registers still at their reset value
  } pin_t;

  typedef struct packed {
    frame_kind_t kind;
    logic [5:0]  len;
    fill_t       fill;
    logic [7:0]  flags;
    logic [15:0] pulse;
    pin_t        pin;
    status_t     status;
  } frame_row_t;

  // directed frames: extremes, every status code and the odd framings
  localparam int DirectedRows = 11;
  frame_row_t directed_rows [DirectedRows] = '{
    // one-byte frame, start and end on the same item, right after reset
    '{FrShort,     6'd1,  FillRand, 8'h00, 16'h0000, PinCleared, StShort},
    // one byte short of a full frame
    '{FrShort,     6'd23, FillOnes, 8'h00, 16'h0000, PinCleared, StShort},
    // all ones, every update flag and the overflow flag
    '{FrGood,      6'd24, FillOnes, 8'hF0, 16'hFFFF, PinStatus,  StOk},
    // all zeros, no data update, pulse count falls back to zero
    '{FrGood,      6'd24, FillZero, 8'h00, 16'h0000, PinStatus,  StOk},
    '{FrBadSum,    6'd24, FillRand, 8'h70, 16'h1234, PinStatus,  StSum},
    '{FrBadHeader, 6'd24, FillRand, 8'h70, 16'h2345, PinStatus,  StHeader},
    // bad checksum wins over a bad header
    '{FrBadBoth,   6'd24, FillRand, 8'h70, 16'h3456, PinStatus,  StSum},
    // extra bytes past the 24th are dropped
    '{FrLong,      6'd31, FillRand, 8'h50, 16'h4000, PinStatus,  StOk},
    // no start marker: the previous end already reset the position
    '{FrNoStart,   6'd24, FillRand, 8'h30, 16'h5000, PinStatus,  StOk},
    '{FrGood,      6'd24, FillRand, 8'hC0, 16'h6000, PinNone,    StOk},
    // count below the previous one without the flag
    '{FrGood,      6'd24, FillRand, 8'h20, 16'h0100, PinNone,    StOk}
  };

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = 8'h00;   // rx_byte
  logic         s_axis_tuser = 1'b0;    // frame_start
  logic         s_axis_tlast = 1'b0;    // frame_end
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // status, voltage_param, voltage_data, current_param, current_data,
  // power_param, power_data, pulse_count, pulse_overflows, zero fill
  logic [199:0] m_axis_tdata;

  energy_meter_frame_parser_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #HalfPeriod clk = ~clk;

  // predictor state: position, stored frame, running sum, meter registers
  logic [PosW-1:0] meter_pos = '0;
  logic [7:0]      meter_frame [FrameLen];
  logic [7:0]      meter_sum = '0;
  result_t         meter_regs = '0;
  result_t         expected_reports [$];

  pin_t    pin_mode = PinNone;
  status_t pin_status = StOk;

  int errors = 0;
  int reports_seen = 0;
  int items_sent = 0;
  int stall_cycles = 0;
  int send_idle = 0;
  int recv_idle = 0;

  initial begin
    for (int i = 0; i < FrameLen; i++) meter_frame[i] = 8'h00;
  end

  function automatic logic [23:0] frame_word(int at);
    return {meter_frame[at], meter_frame[at + 1], meter_frame[at + 2]};
  endfunction

  // one accepted byte: store and sum it, and on the frame end work out the report
  task automatic take_byte(input logic [7:0] b, input logic first, input logic last);
    logic [15:0] pulses;
    logic [7:0]  flags;
    result_t     rep;
    if (first) begin
      meter_pos = '0;
      meter_sum = '0;
    end
    // position saturates at the frame length, later bytes are dropped
    if (meter_pos < FrameLen) begin
      meter_frame[meter_pos] = b;
      if (meter_pos >= SumFirst && meter_pos <= SumLast) meter_sum = meter_sum + b;
      meter_pos = meter_pos + 1'b1;
    end
    if (last) begin
      rep = meter_regs;
      flags = meter_frame[FlagsByte];
      // check order: length, then checksum, then header
      if (meter_pos < FrameLen) begin
        rep.status = StShort;
      end else if (meter_sum != meter_frame[SumByte]) begin
        rep.status = StSum;
      end else if (meter_frame[HeaderByte] != HeaderValue) begin
        rep.status = StHeader;
      end else begin
        rep.status = StOk;
        rep.voltage_param = frame_word(VoltParamAt);
        rep.current_param = frame_word(CurrParamAt);
        rep.power_param   = frame_word(PowParamAt);
        if (flags[FlagVolt]) rep.voltage_data = frame_word(VoltDataAt);
        if (flags[FlagCurr]) rep.current_data = frame_word(CurrDataAt);
        if (flags[FlagPow])  rep.power_data   = frame_word(PowDataAt);
        pulses = {meter_frame[PulseHiByte], meter_frame[PulseLoByte]};
        // one increment for the flag, a wrap of the count, or both
        if (flags[FlagOverflow] || rep.pulse_count > pulses) begin
          rep.pulse_overflows = rep.pulse_overflows + 1'b1;
        end
        rep.pulse_count = pulses;
        meter_regs = rep;
      end
      // a frame end always starts a new frame
      meter_pos = '0;
      meter_sum = '0;
      if (pin_mode == PinCleared) rep = '0;
      if (pin_mode != PinNone) rep.status = pin_status;
      pin_mode = PinNone;
      expected_reports.push_back(rep);
    end
  endtask

  task automatic report_fault(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) begin
      report_fault($sformatf("report %0d %s: got %0h, expected %0h",
                             reports_seen, name, got, want));
    end
  endtask

  task automatic check_report(input logic [199:0] raw);
    result_t got;
    result_t want;
    got = result_t'(raw[ResultW-1:0]);
    if (expected_reports.size() == 0) begin
      report_fault($sformatf("report %0d with none pending, status %0d",
                             reports_seen, got.status));
    end else begin
      want = expected_reports.pop_front();
      compare_field("status",          got.status,          want.status);
      compare_field("voltage_param",   got.voltage_param,   want.voltage_param);
      compare_field("voltage_data",    got.voltage_data,    want.voltage_data);
      compare_field("current_param",   got.current_param,   want.current_param);
      compare_field("current_data",    got.current_data,    want.current_data);
      compare_field("power_param",     got.power_param,     want.power_param);
      compare_field("power_data",      got.power_data,      want.power_data);
      compare_field("pulse_count",     got.pulse_count,     want.pulse_count);
      compare_field("pulse_overflows", got.pulse_overflows, want.pulse_overflows);
      compare_field("zero fill",       raw[199:ResultW],    '0);
    end
    reports_seen++;
  endtask

  // both sides sampled at the rising edge, before the block updates
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) check_report(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready) take_byte(s_axis_tdata, s_axis_tuser, s_axis_tlast);
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // receiver stalls at random, at the phase's rate
  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle);
  end

  // watchdog: too long with no item moving on either side
  initial begin
    while (stall_cycles < StallLimit) @(negedge clk);
    $display("FAILURE");
    $finish;
  end

  task automatic set_idling(input int phase);
    case (phase)
      0: begin
        send_idle = 14;
        recv_idle = 76;
      end
      1: begin
        send_idle = 76;
        recv_idle = 14;
      end
      default: begin
        send_idle = 0;
        recv_idle = 0;
      end
    endcase
  endtask

  // presents one item at the falling edge and holds it until it is taken;
  // returns at the falling edge after acceptance with valid still high
  task automatic send_byte(input logic [7:0] b, input logic first, input logic last);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= first;
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
    @(negedge clk);
  endtask

  // sender holds off until every pending report has come out
  task automatic drain_reports;
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (expected_reports.size() != 0) @(negedge clk);
  endtask

  task automatic send_frame(input frame_kind_t kind, input int len, input fill_t fill,
                            input logic [7:0] flags, input logic [15:0] pulse);
    logic [7:0] fb [MaxFrameBytes];
    logic [7:0] sum;
    int         n;
    for (int i = 0; i < MaxFrameBytes; i++) begin
      case (fill)
        FillZero: fb[i] = 8'h00;
        FillOnes: fb[i] = 8'hFF;
        default:  fb[i] = 8'($urandom_range(255));
      endcase
    end
    fb[HeaderByte]  = HeaderValue;
    fb[FlagsByte]   = flags;
    fb[PulseHiByte] = pulse[15:8];
    fb[PulseLoByte] = pulse[7:0];
    sum = 8'h00;
    for (int i = SumFirst; i <= SumLast; i++) sum = sum + fb[i];
    fb[SumByte] = sum;
    // header is outside the sum, so the two faults can be set apart
    if (kind == FrBadSum || kind == FrBadBoth) begin
      fb[SumByte] = sum + 8'($urandom_range(255, 1));
    end
    if (kind == FrBadHeader || kind == FrBadBoth) begin
      fb[HeaderByte] = HeaderValue ^ 8'($urandom_range(255, 1));
    end
    n = (kind == FrShort || kind == FrLong || kind == FrAbandon) ? len : FrameLen;
    for (int i = 0; i < n; i++) begin
      send_byte(fb[i], (i == 0) && (kind != FrNoStart), (i == n - 1) && (kind != FrAbandon));
    end
  endtask

  // random bytes with scattered start and end markers
  task automatic send_noise(input int n);
    for (int i = 0; i < n; i++) begin
      send_byte(8'($urandom_range(255)), $urandom_range(19) == 0, $urandom_range(29) == 0);
    end
  endtask

  // one random frame, mostly well formed with random content
  task automatic send_random_frame;
    int          pick;
    frame_kind_t kind;
    int          len;
    pick = $urandom_range(99);
    len = FrameLen;
    if (pick < 45) begin
      kind = FrGood;
    end else if (pick < 55) begin
      kind = FrLong;
      len = $urandom_range(31, 25);
    end else if (pick < 62) begin
      kind = FrNoStart;
    end else if (pick < 70) begin
      kind = FrBadSum;
    end else if (pick < 76) begin
      kind = FrBadHeader;
    end else if (pick < 80) begin
      kind = FrBadBoth;
    end else if (pick < 88) begin
      kind = FrShort;
      len = $urandom_range(23, 1);
    end else if (pick < 94) begin
      // broken off without an end, the next frame restarts or carries on
      kind = FrAbandon;
      len = $urandom_range(30, 1);
    end else begin
      send_noise($urandom_range(12, 1));
      return;
    end
    pin_mode = PinNone;
    send_frame(kind, len, FillRand, 8'($urandom_range(255)), 16'($urandom_range(65535)));
  endtask

  initial begin
    int rand_base;
    int phase;
    int cur_phase;
    set_idling(0);
    repeat (ResetCycles) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed frames
    for (int r = 0; r < DirectedRows; r++) begin
      pin_mode   = directed_rows[r].pin;
      pin_status = directed_rows[r].status;
      send_frame(directed_rows[r].kind, directed_rows[r].len, directed_rows[r].fill,
                 directed_rows[r].flags, directed_rows[r].pulse);
    end
    drain_reports();

    // random frames in three idling phases, draining between them
    rand_base = items_sent;
    cur_phase = 0;
    while (items_sent - rand_base < RandomItems) begin
      phase = ((items_sent - rand_base) * 3) / RandomItems;
      if (phase != cur_phase) begin
        drain_reports();
        set_idling(phase);
        cur_phase = phase;
      end
      send_random_frame();
    end

    // let the last reports out, then idle a while for strays
    drain_reports();
    repeat (TailCycles) @(negedge clk);
    if (errors == 0 && expected_reports.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/emfp_pkg.sv
rtl/emfp_capture.sv
rtl/emfp_decode.sv
rtl/energy_meter_frame_parser_unit.sv
tb/energy_meter_frame_parser_unit_test.sv
